// ----- src/cam_generation_trigger_top_defines.svh -----
// Assertion macros for the CAM generation trigger RTL.
// No dependencies; included by cgt_trigger, the module that carries assertions.
`ifndef CAM_GENERATION_TRIGGER_TOP_DEFINES_SVH
`define CAM_GENERATION_TRIGGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CGT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cgt_pkg.sv -----
// Types and constants for the CAM generation trigger.
// No dependencies; imported by every module of the block.
package cgt_pkg;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int MAXI_W     = 10;
    localparam int REP_W      = 3;
    localparam int HEAD_THR_W = 11;
    localparam int DIST_THR_W = 17;
    localparam int SPD_THR_W  = 14;
    localparam int GAP_W      = 16;
    localparam int HEAD_W     = 12;
    localparam int SPD_W      = 14;
    localparam int CAUSE_W    = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_THR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd5;

    // Register reset values
    localparam logic [MAXI_W-1:0]     MAX_INTERVAL_RST = 10'd1000;
    localparam logic [REP_W-1:0]      REPEAT_LIMIT_RST = 3'd3;
    localparam logic [HEAD_THR_W-1:0] HEAD_THR_RST     = 11'd40;
    localparam logic [DIST_THR_W-1:0] DIST_THR_RST     = 17'd400;
    localparam logic [SPD_THR_W-1:0]  SPD_THR_RST      = 14'd50;
    localparam logic [GAP_W-1:0]      GAP_RST          = 16'd500;

    // Heading wrap limits, 0.1 degree units
    localparam logic signed [HEAD_W+1:0] HEAD_HALF = 14'sd1800;
    localparam logic signed [HEAD_W+1:0] HEAD_FULL = 14'sd3600;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_START    = 3'd1,
        CAUSE_HEADING  = 3'd2,
        CAUSE_DISTANCE = 3'd3,
        CAUSE_SPEED    = 3'd4,
        CAUSE_INTERVAL = 3'd5
    } t_cause;

    typedef struct packed {
        logic [MAXI_W-1:0]     max_interval_ms;
        logic [REP_W-1:0]      repeat_limit;
        logic [HEAD_THR_W-1:0] heading_threshold;
        logic [DIST_THR_W-1:0] distance_threshold;
        logic [SPD_THR_W-1:0]  speed_threshold;
        logic [GAP_W-1:0]      container_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] now_ms;
        logic [HEAD_W-1:0] heading;
        logic [WORD_W-1:0] distance_cm;
        logic [SPD_W-1:0]  speed;
        logic              low_freq_ready;
        logic              special_ready;
        logic              send_fails;
    } t_item;

    typedef struct packed {
        logic              generate_res;
        t_cause            cause;
        logic              with_low_freq;
        logic              with_special;
        logic              send_failed;
        logic [WORD_W-1:0] interval_ms;
        logic [WORD_W-1:0] sent_count;
    } t_result;

endpackage

// ----- src/cgt_cfg_regs.sv -----
// Configuration register bank of the CAM generation trigger.
// Depends on cgt_pkg.
module cgt_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cgt_pkg::t_cfg                 o_cfg
);
    import cgt_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_interval_ms    <= MAX_INTERVAL_RST;
            r_cfg.repeat_limit       <= REPEAT_LIMIT_RST;
            r_cfg.heading_threshold  <= HEAD_THR_RST;
            r_cfg.distance_threshold <= DIST_THR_RST;
            r_cfg.speed_threshold    <= SPD_THR_RST;
            r_cfg.container_gap_ms   <= GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_INTERVAL: r_cfg.max_interval_ms    <= i_cfg_data[MAXI_W-1:0];
                CFG_REPEAT_LIMIT: r_cfg.repeat_limit       <= i_cfg_data[REP_W-1:0];
                CFG_HEAD_THR:     r_cfg.heading_threshold  <= i_cfg_data[HEAD_THR_W-1:0];
                CFG_DIST_THR:     r_cfg.distance_threshold <= i_cfg_data[DIST_THR_W-1:0];
                CFG_SPD_THR:      r_cfg.speed_threshold    <= i_cfg_data[SPD_THR_W-1:0];
                CFG_GAP:          r_cfg.container_gap_ms   <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/cgt_trigger.sv -----
// Trigger decision and generation state of the CAM generation trigger.
// Depends on cgt_pkg and cam_generation_trigger_top_defines.svh.
module cgt_trigger #(
    parameter int TIME_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  cgt_pkg::t_item   i_item,
    input  cgt_pkg::t_cfg    i_cfg,
    output cgt_pkg::t_result o_result
);
    import cgt_pkg::*;
    `include "cam_generation_trigger_top_defines.svh"

    localparam int TW = TIME_WIDTH;

    // Generation state
    logic [HEAD_W-1:0] r_last_heading, n_last_heading;
    logic [WORD_W-1:0] r_last_distance, n_last_distance;
    logic [SPD_W-1:0]  r_last_speed, n_last_speed;
    logic [TW-1:0]     r_last_send, n_last_send;
    logic              r_have_sent, n_have_sent;
    logic [TW-1:0]     r_gen_interval, n_gen_interval;
    logic [REP_W-1:0]  r_repeat, n_repeat;
    logic              r_dyn_seen, n_dyn_seen;
    logic [TW-1:0]     r_last_lf, n_last_lf;
    logic              r_lf_valid, n_lf_valid;
    logic [TW-1:0]     r_last_sp, n_last_sp;
    logic              r_sp_valid, n_sp_valid;
    logic [WORD_W-1:0] r_send_total, n_send_total;

    // Width conversions between 32-bit fields and the time width
    logic [TW+WORD_W-1:0] now_ext, gap_ext, maxi_ext, ivl_ext, rst_ivl_ext;
    logic [TW-1:0]        now_t, gap_t, maxi_t, rst_ivl_t;

    assign now_ext     = {{TW{1'b0}}, i_item.now_ms};
    assign now_t       = now_ext[TW-1:0];
    assign gap_ext     = {{(TW+WORD_W-GAP_W){1'b0}}, i_cfg.container_gap_ms};
    assign gap_t       = gap_ext[TW-1:0];
    assign maxi_ext    = {{(TW+WORD_W-MAXI_W){1'b0}}, i_cfg.max_interval_ms};
    assign maxi_t      = maxi_ext[TW-1:0];
    assign rst_ivl_ext = {{(TW+WORD_W-MAXI_W){1'b0}}, MAX_INTERVAL_RST};
    assign rst_ivl_t   = rst_ivl_ext[TW-1:0];

    // Heading change, wrapped into plus or minus 180 degrees
    logic signed [HEAD_W+1:0] hd_raw, hd_wrap;
    logic [HEAD_W+1:0]        hd_mag;
    logic                     head_trig;

    always_comb begin
        hd_raw = $signed({2'b00, i_item.heading}) - $signed({2'b00, r_last_heading});
        if (hd_raw > HEAD_HALF) begin
            hd_wrap = hd_raw - HEAD_FULL;
        end else if (hd_raw < -HEAD_HALF) begin
            hd_wrap = hd_raw + HEAD_FULL;
        end else begin
            hd_wrap = hd_raw;
        end
        hd_mag    = hd_wrap[HEAD_W+1] ? 14'(-hd_wrap) : 14'(hd_wrap);
        head_trig = hd_mag > {3'b000, i_cfg.heading_threshold};
    end

    // Distance change as a wrapped two's complement difference
    logic [WORD_W-1:0] dd, dd_mag;
    logic              dist_trig;

    assign dd        = i_item.distance_cm - r_last_distance;
    assign dd_mag    = dd[WORD_W-1] ? (32'd0 - dd) : dd;
    assign dist_trig = dd_mag > {15'd0, i_cfg.distance_threshold};

    // Speed change
    logic signed [SPD_W:0] sd;
    logic [SPD_W:0]        sd_mag;
    logic                  spd_trig;

    assign sd       = $signed({1'b0, i_item.speed}) - $signed({1'b0, r_last_speed});
    assign sd_mag   = sd[SPD_W] ? 15'(-sd) : 15'(sd);
    assign spd_trig = sd_mag > {1'b0, i_cfg.speed_threshold};

    // Elapsed times since the last send and the last containers
    logic [TW-1:0] el_send, el_lf, el_sp;
    logic          ivl_trig;

    assign el_send  = now_t - r_last_send;
    assign el_lf    = now_t - r_last_lf;
    assign el_sp    = now_t - r_last_sp;
    assign ivl_trig = el_send >= r_gen_interval;

    // Pick the first trigger that holds
    t_cause cause;

    always_comb begin
        if (!i_item.kind) begin
            cause = CAUSE_START;
        end else if (head_trig) begin
            cause = CAUSE_HEADING;
        end else if (dist_trig) begin
            cause = CAUSE_DISTANCE;
        end else if (spd_trig) begin
            cause = CAUSE_SPEED;
        end else if (ivl_trig) begin
            cause = CAUSE_INTERVAL;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    // Attach containers, update the send state and the repeat counter
    logic             attempt, lf_att, sp_att, sent, failed, dynamic;
    logic [REP_W-1:0] rep_inc;

    always_comb begin
        attempt = cause != CAUSE_NONE;
        dynamic = (cause == CAUSE_HEADING) || (cause == CAUSE_DISTANCE)
                  || (cause == CAUSE_SPEED);
        lf_att  = attempt && i_item.low_freq_ready && (!r_lf_valid || (el_lf >= gap_t));
        sp_att  = attempt && i_item.special_ready && (!r_sp_valid || (el_sp >= gap_t));
        failed  = attempt && i_item.send_fails;
        sent    = attempt && !i_item.send_fails;
        rep_inc = r_repeat + 3'd1;

        n_last_heading  = r_last_heading;
        n_last_distance = r_last_distance;
        n_last_speed    = r_last_speed;
        n_last_send     = r_last_send;
        n_have_sent     = r_have_sent;
        n_gen_interval  = r_gen_interval;
        n_repeat        = r_repeat;
        n_dyn_seen      = r_dyn_seen;
        n_last_lf       = r_last_lf;
        n_lf_valid      = r_lf_valid;
        n_last_sp       = r_last_sp;
        n_sp_valid      = r_sp_valid;
        n_send_total    = r_send_total;

        if (attempt) begin
            n_last_heading  = i_item.heading;
            n_last_distance = i_item.distance_cm;
            n_last_speed    = i_item.speed;
        end
        if (lf_att) begin
            n_last_lf  = now_t;
            n_lf_valid = 1'b1;
        end
        if (sp_att) begin
            n_last_sp  = now_t;
            n_sp_valid = 1'b1;
        end
        if (sent) begin
            n_send_total = r_send_total + 32'd1;
            if (r_have_sent) begin
                n_gen_interval = el_send;
            end
            n_last_send = now_t;
            n_have_sent = 1'b1;
            if (dynamic) begin
                n_repeat   = '0;
                n_dyn_seen = 1'b1;
            end else if ((cause == CAUSE_INTERVAL) && r_dyn_seen) begin
                n_repeat = rep_inc;
                if (rep_inc >= i_cfg.repeat_limit) begin
                    n_repeat       = '0;
                    n_gen_interval = maxi_t;
                    n_dyn_seen     = 1'b0;
                end
            end
        end
    end

    // Hold state between items, advance on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_heading  <= '0;
            r_last_distance <= '0;
            r_last_speed    <= '0;
            r_last_send     <= '0;
            r_have_sent     <= 1'b0;
            r_gen_interval  <= rst_ivl_t;
            r_repeat        <= '0;
            r_dyn_seen      <= 1'b0;
            r_last_lf       <= '0;
            r_lf_valid      <= 1'b0;
            r_last_sp       <= '0;
            r_sp_valid      <= 1'b0;
            r_send_total    <= '0;
        end else if (i_step) begin
            r_last_heading  <= n_last_heading;
            r_last_distance <= n_last_distance;
            r_last_speed    <= n_last_speed;
            r_last_send     <= n_last_send;
            r_have_sent     <= n_have_sent;
            r_gen_interval  <= n_gen_interval;
            r_repeat        <= n_repeat;
            r_dyn_seen      <= n_dyn_seen;
            r_last_lf       <= n_last_lf;
            r_lf_valid      <= n_lf_valid;
            r_last_sp       <= n_last_sp;
            r_sp_valid      <= n_sp_valid;
            r_send_total    <= n_send_total;
        end
    end

    // Result of this item, reporting the state after it
    assign ivl_ext = {{WORD_W{1'b0}}, n_gen_interval};

    always_comb begin
        o_result.generate_res  = sent;
        o_result.cause         = cause;
        o_result.with_low_freq = lf_att;
        o_result.with_special  = sp_att;
        o_result.send_failed   = failed;
        o_result.interval_ms   = ivl_ext[WORD_W-1:0];
        o_result.sent_count    = n_send_total;
    end

    `CGT_ASSERT_NEXT(a_count_on_send, i_clk, i_rst_n, i_step && sent,
        r_send_total == $past(r_send_total) + 32'd1, "sent count did not advance on a send")
    `CGT_ASSERT_NEXT(a_fail_keeps_ivl, i_clk, i_rst_n, i_step && failed,
        r_gen_interval == $past(r_gen_interval) && r_last_send == $past(r_last_send),
        "failed send changed the interval state")
    `CGT_ASSERT_SAME(a_no_cause_no_cont, i_clk, i_rst_n, i_step && !attempt,
        !lf_att && !sp_att && !sent && !failed, "activity reported without a trigger")

endmodule

// ----- src/cgt_result_reg.sv -----
// Result register of the CAM generation trigger, output side handshake.
// Depends on cgt_pkg.
module cgt_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cgt_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_free,
    output cgt_pkg::t_result o_result
);
    import cgt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Space for a new item when empty or when the held one leaves now
    assign o_free = !r_valid || !i_stall;

    // Load a new result, drop one that has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/cam_generation_trigger_top.sv -----
// CAM generation trigger: one item is accepted per clock when the result side
// keeps up; each item's result is presented once it has passed the input
// register and the trigger logic into the result register, and a result-side
// stall can hold it in the input register. The rate is set by the update of
// the generation state between those two registers.
// Configuration writes take effect at once and are meant for idle periods;
// there is no clearing pass after reset.
module cam_generation_trigger_top #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [cgt_pkg::WORD_W-1:0]     i_now_ms,
    input  logic [cgt_pkg::HEAD_W-1:0]     i_heading,
    input  logic [cgt_pkg::WORD_W-1:0]     i_distance_cm,
    input  logic [cgt_pkg::SPD_W-1:0]      i_speed,
    input  logic                           i_low_freq_ready,
    input  logic                           i_special_ready,
    input  logic                           i_send_fails,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_generate_res,
    output logic [cgt_pkg::CAUSE_W-1:0]    o_cause,
    output logic                           o_with_low_freq,
    output logic                           o_with_special,
    output logic                           o_send_failed,
    output logic [cgt_pkg::WORD_W-1:0]     o_interval_ms,
    output logic [cgt_pkg::WORD_W-1:0]     o_sent_count,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [cgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cgt_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_result trig_result, out_result;
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    out_free, step, accept;

    cgt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Gather the input fields
    always_comb begin
        in_item.kind           = i_kind;
        in_item.now_ms         = i_now_ms;
        in_item.heading        = i_heading;
        in_item.distance_cm    = i_distance_cm;
        in_item.speed          = i_speed;
        in_item.low_freq_ready = i_low_freq_ready;
        in_item.special_ready  = i_special_ready;
        in_item.send_fails     = i_send_fails;
    end

    // Input register advances whenever the result register has room
    assign step       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (step) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= in_item;
        end
    end

    cgt_trigger #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_trigger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (trig_result)
    );

    cgt_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (trig_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    // Spread the result onto its ports
    assign o_generate_res  = out_result.generate_res;
    assign o_cause         = out_result.cause;
    assign o_with_low_freq = out_result.with_low_freq;
    assign o_with_special  = out_result.with_special;
    assign o_send_failed   = out_result.send_failed;
    assign o_interval_ms   = out_result.interval_ms;
    assign o_sent_count    = out_result.sent_count;

endmodule

// ----- tb/sv/cam_generation_trigger_checker.sv -----
// Scoreboard for the CAM generation trigger: item kind codes, the trigger
// predictor with its own register and history copy, and in-order result checks.
// Depends on cgt_pkg for field widths, register indexes and the cause codes.
`timescale 1ns / 1ps

package cgt_tb_pkg;
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CHECK = 1'b1;
endpackage

module cam_generation_trigger_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel as seen by the block
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_kind,
    input  logic [cgt_pkg::WORD_W-1:0]     i_now_ms,
    input  logic [cgt_pkg::HEAD_W-1:0]     i_heading,
    input  logic [cgt_pkg::WORD_W-1:0]     i_distance_cm,
    input  logic [cgt_pkg::SPD_W-1:0]      i_speed,
    input  logic                           i_low_freq_ready,
    input  logic                           i_special_ready,
    input  logic                           i_send_fails,
    // Result channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_generate_res,
    input  logic [cgt_pkg::CAUSE_W-1:0]    i_cause,
    input  logic                           i_with_low_freq,
    input  logic                           i_with_special,
    input  logic                           i_send_failed,
    input  logic [cgt_pkg::WORD_W-1:0]     i_interval_ms,
    input  logic [cgt_pkg::WORD_W-1:0]     i_sent_count,
    // Register writes
    input  logic                           i_cfg_we,
    input  logic [cgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import cgt_pkg::*;
    import cgt_tb_pkg::*;

    // Register copy and trigger history
    t_cfg              regs;
    logic [HEAD_W-1:0] prev_heading;
    logic [WORD_W-1:0] prev_distance;
    logic [SPD_W-1:0]  prev_speed;
    logic [WORD_W-1:0] last_tx_ms;
    logic              tx_seen;
    logic [WORD_W-1:0] cur_interval;
    logic [REP_W-1:0]  repeat_cnt;
    logic              dyn_seen;
    logic [WORD_W-1:0] lf_stamp;
    logic              lf_stamped;
    logic [WORD_W-1:0] sv_stamp;
    logic              sv_stamped;
    logic [WORD_W-1:0] tx_total;

    t_result cam_decisions_q[$];
    int      mismatches = 0;

    assign o_errors = mismatches;

    // Decide trigger, containers and interval for one item; advance history
    function automatic t_result decide_generation(input t_item it);
        t_result           r;
        int                hd;
        int                sd;
        int                hmag;
        int                smag;
        logic [WORD_W-1:0] dd;
        logic [WORD_W-1:0] dmag;
        logic [WORD_W-1:0] since_tx;
        r        = '0;
        r.cause  = CAUSE_NONE;
        since_tx = it.now_ms - last_tx_ms;
        if (it.kind == KIND_START) begin
            r.cause = CAUSE_START;
        end else begin
            // heading change folded into one half turn either way
            hd = int'(it.heading) - int'(prev_heading);
            if (hd > int'(HEAD_HALF)) begin
                hd -= int'(HEAD_FULL);
            end else if (hd < -int'(HEAD_HALF)) begin
                hd += int'(HEAD_FULL);
            end
            hmag = (hd < 0) ? -hd : hd;
            sd   = int'(it.speed) - int'(prev_speed);
            smag = (sd < 0) ? -sd : sd;
            // distance change read as a signed 32-bit difference
            dd   = it.distance_cm - prev_distance;
            dmag = dd[WORD_W-1] ? (~dd + WORD_W'(1)) : dd;
            if (hmag > int'(regs.heading_threshold)) begin
                r.cause = CAUSE_HEADING;
            end else if (dmag > WORD_W'(regs.distance_threshold)) begin
                r.cause = CAUSE_DISTANCE;
            end else if (smag > int'(regs.speed_threshold)) begin
                r.cause = CAUSE_SPEED;
            end else if (since_tx >= cur_interval) begin
                r.cause = CAUSE_INTERVAL;
            end
        end

        if (r.cause != CAUSE_NONE) begin
            prev_heading  = it.heading;
            prev_distance = it.distance_cm;
            prev_speed    = it.speed;
            // attach containers once their gap has passed
            if (it.low_freq_ready &&
                (!lf_stamped ||
                 (it.now_ms - lf_stamp) >= WORD_W'(regs.container_gap_ms))) begin
                r.with_low_freq = 1'b1;
                lf_stamped      = 1'b1;
                lf_stamp        = it.now_ms;
            end
            if (it.special_ready &&
                (!sv_stamped ||
                 (it.now_ms - sv_stamp) >= WORD_W'(regs.container_gap_ms))) begin
                r.with_special = 1'b1;
                sv_stamped     = 1'b1;
                sv_stamp       = it.now_ms;
            end
            if (it.send_fails) begin
                r.send_failed = 1'b1;
            end else begin
                r.generate_res = 1'b1;
                tx_total       = tx_total + WORD_W'(1);
                if (tx_seen) begin
                    cur_interval = since_tx;
                end
                last_tx_ms = it.now_ms;
                tx_seen    = 1'b1;
                if (r.cause == CAUSE_HEADING || r.cause == CAUSE_DISTANCE ||
                    r.cause == CAUSE_SPEED) begin
                    repeat_cnt = '0;
                    dyn_seen   = 1'b1;
                end else if (r.cause == CAUSE_INTERVAL && dyn_seen) begin
                    repeat_cnt = repeat_cnt + REP_W'(1);
                    if (repeat_cnt >= regs.repeat_limit) begin
                        repeat_cnt   = '0;
                        cur_interval = WORD_W'(regs.max_interval_ms);
                        dyn_seen     = 1'b0;
                    end
                end
            end
        end
        r.interval_ms = cur_interval;
        r.sent_count  = tx_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            regs          = '{MAX_INTERVAL_RST, REPEAT_LIMIT_RST, HEAD_THR_RST,
                              DIST_THR_RST, SPD_THR_RST, GAP_RST};
            prev_heading  = '0;
            prev_distance = '0;
            prev_speed    = '0;
            last_tx_ms    = '0;
            tx_seen       = 1'b0;
            cur_interval  = WORD_W'(MAX_INTERVAL_RST);
            repeat_cnt    = '0;
            dyn_seen      = 1'b0;
            lf_stamp      = '0;
            lf_stamped    = 1'b0;
            sv_stamp      = '0;
            sv_stamped    = 1'b0;
            tx_total      = '0;
            cam_decisions_q.delete();
        end else begin
            // follow register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_INTERVAL: regs.max_interval_ms    = i_cfg_data[MAXI_W-1:0];
                    CFG_REPEAT_LIMIT: regs.repeat_limit       = i_cfg_data[REP_W-1:0];
                    CFG_HEAD_THR:     regs.heading_threshold  = i_cfg_data[HEAD_THR_W-1:0];
                    CFG_DIST_THR:     regs.distance_threshold = i_cfg_data[DIST_THR_W-1:0];
                    CFG_SPD_THR:      regs.speed_threshold    = i_cfg_data[SPD_THR_W-1:0];
                    CFG_GAP:          regs.container_gap_ms   = i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            // compare each delivered result with the oldest decision
            if (i_out_valid && !i_out_stall) begin
                if (cam_decisions_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual cause %0d",
                             $time, i_cause);
                end else begin
                    want = cam_decisions_q.pop_front();
                    check_field("generate_res", WORD_W'(want.generate_res),
                                WORD_W'(i_generate_res));
                    check_field("cause", WORD_W'(want.cause), WORD_W'(i_cause));
                    check_field("with_low_freq", WORD_W'(want.with_low_freq),
                                WORD_W'(i_with_low_freq));
                    check_field("with_special", WORD_W'(want.with_special),
                                WORD_W'(i_with_special));
                    check_field("send_failed", WORD_W'(want.send_failed),
                                WORD_W'(i_send_failed));
                    check_field("interval_ms", want.interval_ms, i_interval_ms);
                    check_field("sent_count", want.sent_count, i_sent_count);
                end
            end
            // predict each accepted item
            if (i_in_valid && !i_in_stall) begin
                it.kind           = i_kind;
                it.now_ms         = i_now_ms;
                it.heading        = i_heading;
                it.distance_cm    = i_distance_cm;
                it.speed          = i_speed;
                it.low_freq_ready = i_low_freq_ready;
                it.special_ready  = i_special_ready;
                it.send_fails     = i_send_fails;
                cam_decisions_q.push_back(decide_generation(it));
            end
        end
        o_pending <= cam_decisions_q.size();
    end

endmodule

// ----- tb/sv/cam_generation_trigger_top_test.sv -----
// Top of the CAM generation trigger testbench: clock, reset, register phases,
// directed and random items, idling on both channels, watchdog and verdict.
// Depends on cgt_pkg, the block and cam_generation_trigger_checker.
`timescale 1ns / 1ps

module cam_generation_trigger_top_test;
    import cgt_pkg::*;
    import cgt_tb_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PHASES          = 6;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  i_kind           = KIND_CHECK;
    logic [WORD_W-1:0]     i_now_ms         = '0;
    logic [HEAD_W-1:0]     i_heading        = '0;
    logic [WORD_W-1:0]     i_distance_cm    = '0;
    logic [SPD_W-1:0]      i_speed          = '0;
    logic                  i_low_freq_ready = 1'b0;
    logic                  i_special_ready  = 1'b0;
    logic                  i_send_fails     = 1'b0;
    logic                  i_out_stall      = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_generate_res;
    logic [CAUSE_W-1:0]    o_cause;
    logic                  o_with_low_freq;
    logic                  o_with_special;
    logic                  o_send_failed;
    logic [WORD_W-1:0]     o_interval_ms;
    logic [WORD_W-1:0]     o_sent_count;

    int errors;
    int pending;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;

    cam_generation_trigger_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_now_ms         (i_now_ms),
        .i_heading        (i_heading),
        .i_distance_cm    (i_distance_cm),
        .i_speed          (i_speed),
        .i_low_freq_ready (i_low_freq_ready),
        .i_special_ready  (i_special_ready),
        .i_send_fails     (i_send_fails),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_generate_res   (o_generate_res),
        .o_cause          (o_cause),
        .o_with_low_freq  (o_with_low_freq),
        .o_with_special   (o_with_special),
        .o_send_failed    (o_send_failed),
        .o_interval_ms    (o_interval_ms),
        .o_sent_count     (o_sent_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    cam_generation_trigger_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_now_ms         (i_now_ms),
        .i_heading        (i_heading),
        .i_distance_cm    (i_distance_cm),
        .i_speed          (i_speed),
        .i_low_freq_ready (i_low_freq_ready),
        .i_special_ready  (i_special_ready),
        .i_send_fails     (i_send_fails),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_generate_res   (o_generate_res),
        .i_cause          (o_cause),
        .i_with_low_freq  (o_with_low_freq),
        .i_with_special   (o_with_special),
        .i_send_failed    (o_send_failed),
        .i_interval_ms    (o_interval_ms),
        .i_sent_count     (o_sent_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    always #1 i_clk = ~i_clk;

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** cam_generation_trigger_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic kind, input logic [WORD_W-1:0] now,
                             input logic [HEAD_W-1:0] head,
                             input logic [WORD_W-1:0] distance,
                             input logic [SPD_W-1:0] spd, input logic lf, input logic sp,
                             input logic fails);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_now_ms         <= now;
        i_heading        <= head;
        i_distance_cm    <= distance;
        i_speed          <= spd;
        i_low_freq_ready <= lf;
        i_special_ready  <= sp;
        i_send_fails     <= fails;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold the sender until every result has been delivered
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(CFG_MAX_INTERVAL, CFG_DATA_W'(c.max_interval_ms));
        write_reg(CFG_REPEAT_LIMIT, CFG_DATA_W'(c.repeat_limit));
        write_reg(CFG_HEAD_THR, CFG_DATA_W'(c.heading_threshold));
        write_reg(CFG_DIST_THR, CFG_DATA_W'(c.distance_threshold));
        write_reg(CFG_SPD_THR, CFG_DATA_W'(c.speed_threshold));
        write_reg(CFG_GAP, CFG_DATA_W'(c.container_gap_ms));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg              c;
        logic [WORD_W-1:0] now_t;
        logic [WORD_W-1:0] dist_t;
        int                head_t;
        int                spd_t;
        int                roll;
        int                pick;
        int                dt;
        int                d;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset settings
        send_item(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0);             // check before any start
        send_item(KIND_CHECK, 1000, 0, 0, 0, 1, 1, 0);          // first send by interval
        send_item(KIND_START, 1100, 0, 0, 0, 1, 1, 1);          // start that fails to send
        send_item(KIND_START, 1200, 0, 0, 0, 0, 0, 0);
        send_item(KIND_CHECK, 1250, 40, 400, 50, 0, 0, 0);      // every change at threshold
        send_item(KIND_CHECK, 1300, 81, 400, 50, 0, 0, 0);
        send_item(KIND_CHECK, 1350, 3599, 400, 50, 0, 0, 0);    // heading wraps backwards
        send_item(KIND_CHECK, 1360, 3599, 801, 50, 0, 0, 0);
        send_item(KIND_CHECK, 1365, 3599, 801, 101, 0, 0, 0);
        send_item(KIND_CHECK, 1370, 3599, 801, 101, 1, 1, 0);   // timed sends up to the limit
        send_item(KIND_CHECK, 1375, 3599, 801, 101, 0, 0, 0);
        send_item(KIND_CHECK, 1380, 3599, 801, 101, 0, 0, 0);
        send_item(KIND_CHECK, 1400, 1780, 32'hFFFF_FFFF, 101, 0, 0, 1); // failed heading send
        send_item(KIND_CHECK, 1500, 1780, 32'hFFFF_FFFF, 16383, 0, 0, 0);
        send_item(KIND_CHECK, 1600, 1780, 32'h7FFF_FFFF, 16383, 0, 0, 0); // half-range distance
        send_item(KIND_CHECK, 1700, 1780, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_item(KIND_CHECK, 32'hFFFF_FFFF, 1780, 32'h7FFF_FFFF, 0, 1, 1, 0);
        send_item(KIND_CHECK, 32'h0000_0010, 1780, 32'h7FFF_FFFF, 0, 1, 1, 0); // time wraps
        send_item(KIND_START, 32'h0000_0200, 0, 0, 0, 1, 1, 0);
        send_item(KIND_CHECK, 32'h0000_0300, 0, 0, 0, 0, 0, 0);

        now_t  = 32'd1000;
        dist_t = '0;
        head_t = 0;
        spd_t  = 0;

        // Random phases, each with its own settings and idling
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_all_results();
            case (phase)
                0: c = '{10'd1000, 3'd3, 11'd40, 17'd400, 14'd50, 16'd500};
                1: c = '{10'd100, 3'd1, 11'd0, 17'd0, 14'd0, 16'd0};
                2: c = '{10'd1000, 3'd7, 11'd1800, 17'd100000, 14'd16383, 16'd65535};
                3: c = '{10'd0, 3'd0, 11'd2047, 17'd131071, 14'd20, 16'd250};
                default: begin
                    c.max_interval_ms    = (phase == 5) ? 10'd1023 :
                                           MAXI_W'($urandom_range(1000, 100));
                    c.repeat_limit       = REP_W'($urandom_range(7, 1));
                    c.heading_threshold  = HEAD_THR_W'($urandom_range(200));
                    c.distance_threshold = DIST_THR_W'($urandom_range(3000));
                    c.speed_threshold    = SPD_THR_W'($urandom_range(400));
                    c.container_gap_ms   = GAP_W'($urandom_range(2000));
                end
            endcase
            apply_settings(c);
            case (phase % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 83; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 83; end
                default: begin tx_gap_pct = 38; rx_stall_pct = 38; end
            endcase
            // cross the time and distance wrap in one phase
            if (phase == 3) begin
                now_t  = 32'hFFFF_F800;
                dist_t = 32'hFFFF_FF00;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0) begin
                    wait_all_results();
                end
                roll = $urandom_range(99);
                if (roll < 10) begin
                    // noise: any field value, time may jump backwards
                    send_item(1'($urandom_range(1)), $urandom(),
                              HEAD_W'($urandom_range(3599)), $urandom(),
                              SPD_W'($urandom_range(16383)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    // advance a plausible vehicle track
                    pick = $urandom_range(99);
                    dt = (pick < 70) ? 100 :
                         (pick < 90) ? int'($urandom_range(1200, 1)) : int'($urandom_range(50));
                    now_t = now_t + dt;
                    pick = $urandom_range(99);
                    if (pick < 75) begin
                        d = int'($urandom_range(20)) - 10;
                    end else if (pick < 95) begin
                        d = int'($urandom_range(120)) - 60;
                    end else begin
                        d = int'($urandom_range(3599));
                    end
                    head_t = (head_t + d + 3600) % 3600;
                    dist_t = dist_t + (spd_t * dt / 1000);
                    pick = $urandom_range(99);
                    if (pick < 10) begin
                        dist_t = dist_t + $urandom_range(2000);
                    end else if (pick < 13) begin
                        dist_t = $urandom();
                    end
                    pick = $urandom_range(99);
                    if (pick < 80) begin
                        spd_t += int'($urandom_range(40)) - 20;
                    end else if (pick < 95) begin
                        spd_t += int'($urandom_range(400)) - 200;
                    end else begin
                        spd_t = $urandom_range(16383);
                    end
                    if (spd_t < 0) begin
                        spd_t = 0;
                    end else if (spd_t > 16383) begin
                        spd_t = 16383;
                    end
                    send_item((roll < 14) ? KIND_START : KIND_CHECK, now_t, HEAD_W'(head_t),
                              dist_t, SPD_W'(spd_t), 1'($urandom_range(1)),
                              1'($urandom_range(1)), ($urandom_range(99) < 8));
                end
            end
        end

        // Drain and settle, then give the verdict
        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** cam_generation_trigger_top: PASSED **");
        end else begin
            $display("** cam_generation_trigger_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/cgt_pkg.sv
src/cgt_cfg_regs.sv
src/cgt_trigger.sv
src/cgt_result_reg.sv
src/cam_generation_trigger_top.sv
tb/sv/cam_generation_trigger_checker.sv
tb/sv/cam_generation_trigger_top_test.sv
